// ===== src/fpd_pkg.sv =====
package fpd_pkg;

  localparam logic [7:0] START_BYTE = 8'h02;
  localparam logic [7:0] TYPE_BYTE  = 8'h40;
  localparam logic [7:0] END_BYTE   = 8'h03;
  // header bytes counted into the length field ahead of the payload
  localparam logic [7:0] LEN_OVERHEAD = 8'd3;

  typedef enum logic [3:0] {
    ST_HUNT,
    ST_STATUS,
    ST_TYPE,
    ST_LENGTH,
    ST_TRANS,
    ST_PAGE,
    ST_LAST_PAGE,
    ST_PAYLOAD,
    ST_END
  } parse_state_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_TYPE,
    ERR_SUM,
    ERR_END
  } err_code_t;

endpackage

// ===== src/framed_packet_deframer_sum8.sv =====
// Byte-stream deframer for STX/ETX framed packets with an 8-bit sum checksum.
// Frame: 0x02, status, 0x40, length, transmission number, page, last page,
// max(length-3,0) payload bytes, checksum, 0x03.
// Input channel (in_valid/in_ready/in_rx_byte): one received byte per
// transaction. Output channel (out_valid/out_ready/out_*): exactly one result
// transaction per input byte, in order. A result carries the payload byte
// when the input byte was payload, a packet-done flag on a good end byte, an
// error code (wrong type, checksum mismatch, bad end byte), the header fields
// as held after that byte, and the 16-bit wrapping packet count.
// Latency: the result is registered and valid the cycle after the input byte
// is accepted. Throughput: one byte per cycle; the whole parse step is one
// pass of logic through the parser state and the single output register.
// Stall: while the output register holds an untaken result and out_ready is
// low, in_ready drops; when out_ready is high a new byte is accepted in the
// same cycle the old result leaves.
// Reset (rst_n low, synchronous): parser goes back to hunting for the start
// byte, header fields, checksum and packet count clear, no result pending.
module framed_packet_deframer_sum8
  import fpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic        out_packet_done,
  output logic [1:0]  out_error_code,
  output logic [7:0]  out_frame_status,
  output logic [7:0]  out_frame_length,
  output logic [7:0]  out_transmission_number,
  output logic [7:0]  out_page_number,
  output logic [7:0]  out_last_page_number,
  output logic [15:0] out_packets_received
);

  // parser state and frame registers
  parse_state_t state_r, state_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [7:0]  trans_r, trans_nxt;
  logic [7:0]  page_r, page_nxt;
  logic [7:0]  last_page_r, last_page_nxt;
  logic [7:0]  pay_cnt_r, pay_cnt_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] pkt_cnt_r, pkt_cnt_nxt;

  // result register
  logic        out_valid_r;
  logic        pvalid_r, pvalid_nxt;
  logic [7:0]  pbyte_r, pbyte_nxt;
  logic        done_r, done_nxt;
  err_code_t   err_r, err_nxt;

  logic in_fire;
  logic in_payload;   // byte in payload phase is still payload (not checksum)

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign in_payload = (length_r > LEN_OVERHEAD) &&
                      (pay_cnt_r < (length_r - LEN_OVERHEAD));

  // next parser state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_HUNT:      if (in_rx_byte == START_BYTE) state_nxt = ST_STATUS;
      ST_STATUS:    state_nxt = ST_TYPE;
      ST_TYPE:      state_nxt = (in_rx_byte == TYPE_BYTE) ? ST_LENGTH : ST_HUNT;
      ST_LENGTH:    state_nxt = ST_TRANS;
      ST_TRANS:     state_nxt = ST_PAGE;
      ST_PAGE:      state_nxt = ST_LAST_PAGE;
      ST_LAST_PAGE: state_nxt = ST_PAYLOAD;
      ST_PAYLOAD:   if (!in_payload) state_nxt = ST_END;
      ST_END:       state_nxt = ST_HUNT;
      default:      state_nxt = ST_HUNT;
    endcase
  end

  // datapath and result fields
  always_comb begin
    status_nxt    = status_r;
    length_nxt    = length_r;
    trans_nxt     = trans_r;
    page_nxt      = page_r;
    last_page_nxt = last_page_r;
    pay_cnt_nxt   = pay_cnt_r;
    sum_nxt       = sum_r;
    pkt_cnt_nxt   = pkt_cnt_r;
    pvalid_nxt    = 1'b0;
    pbyte_nxt     = 8'h00;
    done_nxt      = 1'b0;
    err_nxt       = ERR_NONE;
    case (state_r)
      ST_STATUS: begin
        status_nxt  = in_rx_byte;
        // type byte is fixed, so it goes into the sum up front
        sum_nxt     = in_rx_byte + TYPE_BYTE;
        pay_cnt_nxt = 8'd0;
      end
      ST_TYPE: begin
        if (in_rx_byte != TYPE_BYTE) err_nxt = ERR_TYPE;
      end
      ST_LENGTH: begin
        length_nxt = in_rx_byte;
        sum_nxt    = sum_r + in_rx_byte;
      end
      ST_TRANS: begin
        trans_nxt = in_rx_byte;
        sum_nxt   = sum_r + in_rx_byte;
      end
      ST_PAGE: begin
        page_nxt = in_rx_byte;
        sum_nxt  = sum_r + in_rx_byte;
      end
      ST_LAST_PAGE: begin
        last_page_nxt = in_rx_byte;
        sum_nxt       = sum_r + in_rx_byte;
      end
      ST_PAYLOAD: begin
        if (in_payload) begin
          pvalid_nxt  = 1'b1;
          pbyte_nxt   = in_rx_byte;
          pay_cnt_nxt = pay_cnt_r + 8'd1;
          sum_nxt     = sum_r + in_rx_byte;
        end else if (sum_r != in_rx_byte) begin
          // mismatch is flagged but the frame still runs to its end byte
          err_nxt = ERR_SUM;
        end
      end
      ST_END: begin
        if (in_rx_byte == END_BYTE) begin
          pkt_cnt_nxt = pkt_cnt_r + 16'd1;
          done_nxt    = 1'b1;
        end else begin
          err_nxt = ERR_END;
        end
        pay_cnt_nxt = 8'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HUNT;
      status_r    <= 8'd0;
      length_r    <= 8'd0;
      trans_r     <= 8'd0;
      page_r      <= 8'd0;
      last_page_r <= 8'd0;
      pay_cnt_r   <= 8'd0;
      sum_r       <= 8'd0;
      pkt_cnt_r   <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r     <= state_nxt;
        status_r    <= status_nxt;
        length_r    <= length_nxt;
        trans_r     <= trans_nxt;
        page_r      <= page_nxt;
        last_page_r <= last_page_nxt;
        pay_cnt_r   <= pay_cnt_nxt;
        sum_r       <= sum_nxt;
        pkt_cnt_r   <= pkt_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload: loaded with each accepted byte, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pvalid_r <= pvalid_nxt;
      pbyte_r  <= pbyte_nxt;
      done_r   <= done_nxt;
      err_r    <= err_nxt;
    end
  end

  // header fields and count are shown as held after the byte
  assign out_valid               = out_valid_r;
  assign out_payload_valid       = pvalid_r;
  assign out_payload_byte        = pbyte_r;
  assign out_packet_done         = done_r;
  assign out_error_code          = err_r;
  assign out_frame_status        = status_r;
  assign out_frame_length        = length_r;
  assign out_transmission_number = trans_r;
  assign out_page_number         = page_r;
  assign out_last_page_number    = last_page_r;
  assign out_packets_received    = pkt_cnt_r;

endmodule
